>>> design/medf_pkg.sv
`timescale 1ns / 1ps

package medf_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  // Field widths.
  localparam int PIX_W   = 24;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 12;
  localparam int WREG_W  = 12;
  localparam int HREG_W  = 13;
  localparam int CFG_W   = 13;
  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int WIN_N   = 9;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } medf_reg_e;

  localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(640);
  localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(480);

  typedef logic [PIX_W-1:0] medf_pix_t;

  // Coordinates and end-of-frame flag that travel alongside a result.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } medf_meta_t;

  // Three values in ascending order.
  typedef struct packed {
    medf_pix_t hi;
    medf_pix_t mid;
    medf_pix_t lo;
  } medf_tri_t;

  function automatic medf_tri_t sort3(medf_pix_t a, medf_pix_t b, medf_pix_t c);
    medf_pix_t x0, x1, y0, y1, z0, z1;
    medf_tri_t t;
    x0 = (a < b) ? a : b;
    x1 = (a < b) ? b : a;
    y0 = (x1 < c) ? x1 : c;
    y1 = (x1 < c) ? c : x1;
    z0 = (x0 < y0) ? x0 : y0;
    z1 = (x0 < y0) ? y0 : x0;
    t.lo  = z0;
    t.mid = z1;
    t.hi  = y1;
    return t;
  endfunction

  function automatic medf_pix_t max3(medf_pix_t a, medf_pix_t b, medf_pix_t c);
    medf_pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic medf_pix_t min3(medf_pix_t a, medf_pix_t b, medf_pix_t c);
    medf_pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic medf_pix_t med3(medf_pix_t a, medf_pix_t b, medf_pix_t c);
    medf_pix_t lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

>>> design/medf_line_buf.sv
`timescale 1ns / 1ps

module medf_line_buf import medf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  medf_pix_t         pix_i,
  output medf_pix_t         up_o,
  output medf_pix_t         mid_o
);

  medf_pix_t upper_mem  [MAX_WIDTH];
  medf_pix_t middle_mem [MAX_WIDTH];

  medf_pix_t         up_rd_q, mid_rd_q;
  logic              wr_pend_q;
  logic [ADDR_W-1:0] wr_addr_q;

  // The middle line is read and overwritten with the new pixel at the same
  // edge; the read returns the old word.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      middle_mem[addr_i] <= pix_i;
      mid_rd_q           <= middle_mem[addr_i];
      up_rd_q            <= upper_mem[addr_i];
    end
  end

  // The old middle word moves up in the next cycle, once it sits in the read
  // register. The next read of that column is at least three words away.
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      upper_mem[wr_addr_q] <= mid_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= rd_en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      wr_addr_q <= addr_i;
    end
  end

  assign up_o  = up_rd_q;
  assign mid_o = mid_rd_q;

endmodule

>>> design/medf_median.sv
`timescale 1ns / 1ps

module medf_median import medf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_emit_i,
  input  medf_meta_t in_meta_i,
  input  medf_pix_t  up_i,
  input  medf_pix_t  mid_i,
  input  medf_pix_t  pix_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output medf_pix_t  out_median_o,
  output medf_meta_t out_meta_o
);

  medf_pix_t  win_q [WIN_N];
  logic       win_v_q;
  medf_meta_t win_meta_q;

  medf_tri_t  col_q [3];
  logic       col_v_q;
  medf_meta_t col_meta_q;

  medf_pix_t  cand_q [3];
  logic       cand_v_q;
  medf_meta_t cand_meta_q;

  medf_pix_t  med_q;
  logic       out_v_q;
  medf_meta_t out_meta_q;

  logic out_rdy, cand_rdy, col_rdy, win_rdy;
  logic in_fire;

  assign out_rdy  = !out_v_q  || out_ready_i;
  assign cand_rdy = !cand_v_q || out_rdy;
  assign col_rdy  = !col_v_q  || cand_rdy;
  assign win_rdy  = !win_v_q  || col_rdy;
  assign in_fire  = in_valid_i && win_rdy;

  assign in_ready_o = win_rdy;

  // Window: rows top to bottom, columns left to right; every word shifts it.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]     <= win_q[k*3 + 1];
        win_q[k*3 + 1] <= win_q[k*3 + 2];
      end
      win_q[2]   <= up_i;
      win_q[5]   <= mid_i;
      win_q[8]   <= pix_i;
      win_meta_q <= in_meta_i;
    end
  end

  // Sort each column.
  always_ff @(posedge clk_i) begin
    if (win_v_q && col_rdy) begin
      for (int k = 0; k < 3; k++) begin
        col_q[k] <= sort3(win_q[k], win_q[k + 3], win_q[k + 6]);
      end
      col_meta_q <= win_meta_q;
    end
  end

  // Largest low, middle of middles, smallest high.
  always_ff @(posedge clk_i) begin
    if (col_v_q && cand_rdy) begin
      cand_q[0]   <= max3(col_q[0].lo, col_q[1].lo, col_q[2].lo);
      cand_q[1]   <= med3(col_q[0].mid, col_q[1].mid, col_q[2].mid);
      cand_q[2]   <= min3(col_q[0].hi, col_q[1].hi, col_q[2].hi);
      cand_meta_q <= col_meta_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_v_q && out_rdy) begin
      med_q      <= med3(cand_q[0], cand_q[1], cand_q[2]);
      out_meta_q <= cand_meta_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_v_q  <= 1'b0;
      col_v_q  <= 1'b0;
      cand_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (win_rdy) begin
        win_v_q <= in_valid_i && in_emit_i;
      end
      if (col_rdy) begin
        col_v_q <= win_v_q;
      end
      if (cand_rdy) begin
        cand_v_q <= col_v_q;
      end
      if (out_rdy) begin
        out_v_q <= cand_v_q;
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_median_o = med_q;
  assign out_meta_o   = out_meta_q;

endmodule

>>> design/median_filter_3x3_stream.sv
`timescale 1ns / 1ps

// Channel   | Direction | Signals                      | Contents
// ----------+-----------+------------------------------+---------------------------------
// pixel in  | in        | s_axis_tvalid/tready/tdata   | tdata[23:0] pixel_value
// median out| out       | m_axis_tvalid/tready/tdata   | tdata[23:0] median_value,
//           |           | m_axis_tlast                 | [35:24] out_row, [46:36] out_column
// config    | in        | cfg_we_i/cfg_idx_i/cfg_wdata | 0 image_width, 1 image_height
//
// One word is accepted every cycle while the output does not stall; the word
// that completes a window passes the line buffer read register, the window
// register and the three median stages before its median leaves.
// Reset clears the counters and the stage valids and sets the size registers to 640 x 480.
// The line buffers are not cleared: the first two rows of a frame fill every
// column before any result reads them.
// Each stage holds its word while the next one is full, so a stall on the
// output backs up only as far as it needs to.

module median_filter_3x3_stream import medf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // [23:0] pixel_value

  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [23:0] median_value, [35:24] out_row,
                                           // [46:36] out_column, [47] zero
  output logic             m_axis_tlast,   // frame_done

  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  // Size registers and their clamped working values.
  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;
  logic [WREG_W-1:0] eff_w;
  logic [HREG_W-1:0] eff_h;

  // Position of the next incoming word.
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // Stage one: the accepted word beside the line buffer read data.
  logic       s1_v_q;
  logic       s1_emit_q;
  medf_pix_t  s1_pix_q;
  medf_meta_t s1_meta_q;

  logic       in_fire;
  logic       s1_ready;
  logic       med_ready;
  logic       emit;
  medf_meta_t meta;
  medf_pix_t  up_rd, mid_rd;
  medf_pix_t  median;
  medf_meta_t out_meta;

  always_comb begin
    if (width_q < WREG_W'(3)) begin
      eff_w = WREG_W'(3);
    end else if (width_q > WREG_W'(MAX_WIDTH)) begin
      eff_w = WREG_W'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q < HREG_W'(3)) begin
      eff_h = HREG_W'(3);
    end else if (height_q > HREG_W'(MAX_HEIGHT)) begin
      eff_h = HREG_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
  end

  assign s1_ready      = !s1_v_q || med_ready;
  assign s_axis_tready = s1_ready;
  assign in_fire       = s_axis_tvalid && s1_ready;

  // The window around (row-1, col-1) is complete once row and col reach two.
  always_comb begin
    emit      = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
    meta.row  = row_q - ROW_W'(1);
    meta.col  = col_q - COL_W'(1);
    meta.last = ({1'b0, row_q} == eff_h - HREG_W'(1)) &&
                ({1'b0, col_q} == eff_w - WREG_W'(1));
  end

  // Raster counters: the column wraps at the width, the row at the height.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if ({1'b0, col_q} + WREG_W'(1) >= eff_w) begin
        col_d = '0;
        if ({1'b0, row_q} + HREG_W'(1) >= eff_h) begin
          row_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // Any register write starts a new frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      case (medf_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[WREG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[HREG_W-1:0];
        default:          width_q  <= width_q;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= s_axis_tdata;
      s1_emit_q <= emit;
      s1_meta_q <= meta;
    end
  end

  medf_line_buf u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_fire),
    .addr_i  (col_q[ADDR_W-1:0]),
    .pix_i   (s_axis_tdata),
    .up_o    (up_rd),
    .mid_o   (mid_rd)
  );

  medf_median u_median (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s1_v_q),
    .in_ready_o   (med_ready),
    .in_emit_i    (s1_emit_q),
    .in_meta_i    (s1_meta_q),
    .up_i         (up_rd),
    .mid_i        (mid_rd),
    .pix_i        (s1_pix_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_median_o (median),
    .out_meta_o   (out_meta)
  );

  assign m_axis_tdata = {1'b0, out_meta.col, out_meta.row, median};
  assign m_axis_tlast = out_meta.last;

endmodule
